FILE: design/mcr_pkg.sv
// Shared types, codes and reset values for the Manchester receiver.
package mcr_pkg;

  // Item operation codes carried in the slave tuser
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ARM  = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_MIN_SHORT  = 3'd0;
  localparam logic [2:0] REG_MAX_SHORT  = 3'd1;
  localparam logic [2:0] REG_MIN_LONG   = 3'd2;
  localparam logic [2:0] REG_MAX_LONG   = 3'd3;
  localparam logic [2:0] REG_SYNC_MIN   = 3'd4;
  localparam logic [2:0] REG_SYNC_MAX   = 3'd5;
  localparam logic [2:0] REG_INIT_LIMIT = 3'd6;

  // Configuration reset values
  localparam logic [7:0] RST_MIN_SHORT  = 8'd33;
  localparam logic [7:0] RST_MAX_SHORT  = 8'd65;
  localparam logic [7:0] RST_MIN_LONG   = 8'd66;
  localparam logic [7:0] RST_MAX_LONG   = 8'd129;
  localparam logic [6:0] RST_SYNC_MIN   = 7'd1;
  localparam logic [6:0] RST_SYNC_MAX   = 7'd16;
  localparam logic [7:0] RST_INIT_LIMIT = 8'd2;
  localparam logic [7:0] RST_BYTE_LIMIT = 8'd2;

  // Interval counter step per tick and half-bits per byte
  localparam logic [7:0] TICK_STEP     = 8'd8;
  localparam logic [4:0] HALF_PER_BYTE = 5'd16;

  // Mode numbers as reported on the result channel
  localparam logic [2:0] MODE_NUM_PRE  = 3'd0;
  localparam logic [2:0] MODE_NUM_SYNC = 3'd1;
  localparam logic [2:0] MODE_NUM_DATA = 3'd2;
  localparam logic [2:0] MODE_NUM_MSG  = 3'd3;
  localparam logic [2:0] MODE_NUM_IDLE = 3'd4;

  // Receiver state machine
  typedef enum logic [4:0] {
    MODE_PRE  = 5'b00001,
    MODE_SYNC = 5'b00010,
    MODE_DATA = 5'b00100,
    MODE_MSG  = 5'b01000,
    MODE_IDLE = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [7:0] min_short;
    logic [7:0] max_short;
    logic [7:0] min_long;
    logic [7:0] max_long;
    logic [6:0] sync_min;
    logic [6:0] sync_max;
    logic [7:0] init_limit;
  } cfg_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       message_done;
    logic [2:0] mode;
  } res_t;

  // Half-bit assembler state plus the byte it may complete
  typedef struct packed {
    logic [15:0] shift;
    logic [4:0]  cnt;
    logic [7:0]  bcount;
    logic [7:0]  blimit;
    logic        got;
    logic [7:0]  data;
    logic [7:0]  idx;
  } hb_t;

  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] c;
    unique case (m)
      MODE_PRE:  c = MODE_NUM_PRE;
      MODE_SYNC: c = MODE_NUM_SYNC;
      MODE_DATA: c = MODE_NUM_DATA;
      MODE_MSG:  c = MODE_NUM_MSG;
      default:   c = MODE_NUM_IDLE;
    endcase
    return c;
  endfunction

endpackage

FILE: design/mcr_cfg.sv
// Configuration register file of the Manchester receiver.
module mcr_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [2:0]    idx_i,
  input  logic [7:0]    wdata_i,
  output mcr_pkg::cfg_t cfg_o
);

  mcr_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write index
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        mcr_pkg::REG_MIN_SHORT:  cfg_d.min_short  = wdata_i;
        mcr_pkg::REG_MAX_SHORT:  cfg_d.max_short  = wdata_i;
        mcr_pkg::REG_MIN_LONG:   cfg_d.min_long   = wdata_i;
        mcr_pkg::REG_MAX_LONG:   cfg_d.max_long   = wdata_i;
        mcr_pkg::REG_SYNC_MIN:   cfg_d.sync_min   = wdata_i[6:0];
        mcr_pkg::REG_SYNC_MAX:   cfg_d.sync_max   = wdata_i[6:0];
        mcr_pkg::REG_INIT_LIMIT: cfg_d.init_limit = wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_short  <= mcr_pkg::RST_MIN_SHORT;
      cfg_q.max_short  <= mcr_pkg::RST_MAX_SHORT;
      cfg_q.min_long   <= mcr_pkg::RST_MIN_LONG;
      cfg_q.max_long   <= mcr_pkg::RST_MAX_LONG;
      cfg_q.sync_min   <= mcr_pkg::RST_SYNC_MIN;
      cfg_q.sync_max   <= mcr_pkg::RST_SYNC_MAX;
      cfg_q.init_limit <= mcr_pkg::RST_INIT_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/mcr_core.sv
// Receiver state and single-pass next-state logic for one item.
module mcr_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [1:0]    op_i,
  input  logic          raw_i,
  input  mcr_pkg::cfg_t cfg_i,
  output mcr_pkg::res_t res_o
);

  mcr_pkg::mode_e mode_q, mode_d;
  logic           prev_q, prev_d;
  logic           filt_q, filt_d;
  logic           last_q, last_d;
  logic [7:0]     ic_q, ic_d;
  logic [7:0]     st_q, st_d;
  mcr_pkg::hb_t   hb_q, hb_d;

  logic       edge_det;
  logic       filt_n;
  logic [7:0] ic_inc;
  logic [7:0] st_inc;
  logic [7:0] tmin;
  logic [7:0] tmax;
  logic       short_bad;
  logic       long_bad;
  logic       in_range;
  mcr_pkg::hb_t hb_a;
  mcr_pkg::hb_t hb_b;

  // Shift one half-bit in; pack and count a byte after sixteen
  function automatic mcr_pkg::hb_t push_half(mcr_pkg::hb_t h, logic b);
    mcr_pkg::hb_t r;
    logic [7:0]   v;
    r       = h;
    r.shift = {h.shift[14:0], b};
    r.cnt   = h.cnt + 5'd1;
    if (r.cnt == mcr_pkg::HALF_PER_BYTE) begin
      for (int k = 0; k < 8; k++) begin
        v[k] = r.shift[14 - 2 * k];
      end
      r.got    = 1'b1;
      r.data   = v;
      r.idx    = h.bcount;
      r.bcount = h.bcount + 8'd1;
      if (r.bcount == 8'd1) begin
        r.blimit = v;
      end
      r.shift = '0;
      r.cnt   = '0;
    end
    return r;
  endfunction

  // Glitch filter, edge detect and interval timing
  assign ic_inc    = ic_q + mcr_pkg::TICK_STEP;
  assign filt_n    = (raw_i == prev_q) ? raw_i : filt_q;
  assign edge_det  = (filt_n != last_q);
  assign tmin      = {cfg_i.sync_min, 1'b0};
  assign tmax      = {cfg_i.sync_max, 1'b0};
  assign st_inc    = st_q + 8'd1;
  assign short_bad = (ic_inc < cfg_i.min_short) || (ic_inc > cfg_i.max_short);
  assign long_bad  = (ic_inc < cfg_i.min_short) || (ic_inc > cfg_i.max_long);
  assign in_range  = !long_bad;

  // Data mode: optional doubled half-bit, then the current level
  always_comb begin
    hb_a     = hb_q;
    hb_a.got = 1'b0;
    hb_a.data = '0;
    hb_a.idx  = '0;
    if (ic_inc >= cfg_i.min_long) begin
      hb_a = push_half(hb_a, last_q);
    end
    hb_b = push_half(hb_a, filt_n);
  end

  // Next state for the item in hand
  always_comb begin
    mode_d = mode_q;
    prev_d = prev_q;
    filt_d = filt_q;
    last_d = last_q;
    ic_d   = ic_q;
    st_d   = st_q;
    hb_d   = hb_q;
    hb_d.got  = 1'b0;
    hb_d.data = '0;
    hb_d.idx  = '0;
    case (op_i)
      mcr_pkg::OP_TICK: begin
        if (mode_q == mcr_pkg::MODE_PRE || mode_q == mcr_pkg::MODE_SYNC ||
            mode_q == mcr_pkg::MODE_DATA) begin
          prev_d = raw_i;
          filt_d = filt_n;
          last_d = filt_n;
          ic_d   = ic_inc;
          unique case (mode_q)
            mcr_pkg::MODE_PRE: begin
              if (edge_det && filt_n) begin
                ic_d   = '0;
                st_d   = '0;
                mode_d = mcr_pkg::MODE_SYNC;
              end
            end
            mcr_pkg::MODE_SYNC: begin
              if (edge_det) begin
                if (((st_q < tmin) || last_q) && short_bad) begin
                  mode_d = mcr_pkg::MODE_PRE;
                end else if (!last_q && long_bad) begin
                  mode_d = mcr_pkg::MODE_PRE;
                end else begin
                  st_d = st_inc;
                  ic_d = '0;
                  if (!last_q && (st_inc >= tmin) && (ic_inc >= cfg_i.min_long)) begin
                    mode_d      = mcr_pkg::MODE_DATA;
                    hb_d.shift  = '0;
                    hb_d.cnt    = '0;
                    hb_d.bcount = '0;
                  end else if (st_inc >= tmax) begin
                    mode_d = mcr_pkg::MODE_PRE;
                  end
                end
              end
            end
            default: begin
              if (edge_det) begin
                if (!in_range) begin
                  mode_d = mcr_pkg::MODE_PRE;
                end else if (filt_n && (hb_a.bcount >= hb_a.blimit)) begin
                  hb_d   = hb_a;
                  mode_d = mcr_pkg::MODE_MSG;
                end else begin
                  hb_d = hb_b;
                  ic_d = '0;
                end
              end
            end
          endcase
        end
      end
      mcr_pkg::OP_ARM: begin
        hb_d.blimit = cfg_i.init_limit;
        mode_d      = mcr_pkg::MODE_PRE;
      end
      mcr_pkg::OP_STOP: begin
        mode_d = mcr_pkg::MODE_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mcr_pkg::MODE_IDLE;
      prev_q <= 1'b0;
      filt_q <= 1'b0;
      last_q <= 1'b0;
      ic_q   <= '0;
      st_q   <= '0;
      hb_q   <= '{shift: '0, cnt: '0, bcount: '0, blimit: mcr_pkg::RST_BYTE_LIMIT,
                  got: 1'b0, data: '0, idx: '0};
    end else if (step_i) begin
      mode_q <= mode_d;
      prev_q <= prev_d;
      filt_q <= filt_d;
      last_q <= last_d;
      ic_q   <= ic_d;
      st_q   <= st_d;
      hb_q   <= hb_d;
    end
  end

  // Result of the item in hand
  assign res_o.byte_valid   = hb_d.got;
  assign res_o.data_byte    = hb_d.data;
  assign res_o.byte_index   = hb_d.idx;
  assign res_o.message_done = (mode_d == mcr_pkg::MODE_MSG);
  assign res_o.mode         = mcr_pkg::mode_code(mode_d);

  // A byte completes only while decoding data
  a_byte_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.byte_valid |-> (mode_q == mcr_pkg::MODE_DATA && op_i == mcr_pkg::OP_TICK))
    else $error("byte completed outside data mode");

  // Idle and message done freeze the filter and the counter
  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && op_i == mcr_pkg::OP_TICK &&
     (mode_q == mcr_pkg::MODE_MSG || mode_q == mcr_pkg::MODE_IDLE))
    |=> ($stable(ic_q) && $stable(filt_q) && $stable(prev_q) && $stable(mode_q)))
    else $error("tick changed state while frozen");

  // Arm enters preamble wait with the configured byte limit
  a_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && op_i == mcr_pkg::OP_ARM)
    |=> (mode_q == mcr_pkg::MODE_PRE && hb_q.blimit == $past(cfg_i.init_limit)))
    else $error("arm did not load byte limit");

  // State holds while no item is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(mode_q) && $stable(hb_q) && $stable(ic_q)))
    else $error("state changed without an item");

endmodule

FILE: design/manchester_receiver_with_sync.sv
// Top level of the Manchester receiver: stream handshake, input and result registers.
//
// Usage: each slave transfer carries one item. s_axis_tuser holds the operation
// (sample tick, arm, stop) and s_axis_tdata bit 0 the raw line sample. Every
// item yields exactly one master transfer with the decoded byte (when one
// completed, flagged by m_axis_tuser), its position in the message, the
// message-done flag and the receiver mode after the item.
// Configuration registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i
// while no item is in flight.
// An accepted item sits in the input register; its result enters the output register
// once that register can take it, and m_axis_tvalid then rises with the result.
// Throughput: one item per cycle while the master side does not stall, set by the single-pass state update.
// When the master side stalls, the result register holds and the input register
// fills; s_axis_tready drops only when both are occupied, and rises again in
// the cycle the result transfer completes.
// Reset puts the receiver in idle, restores the default thresholds and byte
// limit and empties both registers.
module manchester_receiver_with_sync (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  // Slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] raw_sample, [7:1] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // Master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [15:8] byte_index,
                                      // [16] message_done, [19:17] mode, [23:20] zero
  output logic        m_axis_tuser    // [0] byte_valid
);

  mcr_pkg::cfg_t cfg;
  mcr_pkg::res_t res;
  mcr_pkg::res_t out_q;

  logic       s1_vld_q, s1_vld_d;
  logic [1:0] s1_op_q;
  logic       s1_raw_q;
  logic       out_vld_q, out_vld_d;
  logic       out_free;
  logic       step;

  mcr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  mcr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .op_i   (s1_op_q),
    .raw_i  (s1_raw_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Advance the item when the result register can take it
  assign out_free      = !out_vld_q || m_axis_tready;
  assign step          = s1_vld_q && out_free;
  assign s_axis_tready = !s1_vld_q || out_free;
  assign s1_vld_d      = (s_axis_tvalid && s_axis_tready) || (s1_vld_q && !out_free);
  assign out_vld_d     = step || (out_vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Capture the input transfer
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_op_q  <= s_axis_tuser;
      s1_raw_q <= s_axis_tdata[0];
    end
  end

  // Hold the result until its transfer completes
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.byte_valid;
  assign m_axis_tdata  = {4'd0, out_q.mode, out_q.message_done,
                          out_q.byte_index, out_q.data_byte};

endmodule
